@@ design/hcb_pkg.sv @@
`default_nettype none
package hcb_pkg;
	localparam int MaxSymbols = 32;
	localparam int WeightBits = 16;
	localparam int NodeCount = 2 * MaxSymbols - 1;
	localparam int NodeBits = $clog2(NodeCount + 1);
	localparam int SymBits = $clog2(MaxSymbols);
	localparam int CountBits = $clog2(MaxSymbols + 1);
	localparam int SumBits = WeightBits + SymBits;
	localparam int CodeBits = 31;
	localparam int LenBits = 5;
	localparam int StackBits = $clog2(MaxSymbols + 1);

	typedef enum logic [1:0] {
		ST_CODE = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_A,
		S_SCAN_B,
		S_MERGE,
		S_POP,
		S_POP_WAIT,
		S_VISIT,
		S_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic op;
		logic [15:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] symbol;
		logic [4:0] code_length;
		logic [30:0] code;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [NodeBits-1:0] node;
		logic [LenBits-1:0] depth;
		logic [CodeBits-1:0] code;
	} visit_t;
endpackage
`default_nettype wire

@@ design/huffman_code_builder.sv @@
`default_nettype none
// Huffman code builder. An add item (op 0) stores a weight and returns one item with the
// new symbol index (or a full flag when 32 symbols are held) through the output register.
// A build item (op 1) returns an empty item if no symbol is held; else it merges the two
// lightest live nodes until one remains, then walks the tree in left-first preorder and
// returns one code item per symbol, last set on the final one; ties go to the lowest node
// index. The build is set by a serial scan of the node weight memory, one node per cycle:
// each merge scans for the lightest and next lightest node, a closing pair of scans ends
// the merging, and the walk visits each node, with output stalls and a done state.
// No item is taken in a build or while the output stalls; a build empties the store.
module huffman_code_builder
	import hcb_pkg::*;
(
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire out_ready,
	output out_item_t out_data
);
	// Node weight memory, child memory and visit stack memory.
	logic [SumBits-1:0] wmem [NodeCount];
	logic [2*NodeBits-1:0] cmem [MaxSymbols];
	visit_t smem [MaxSymbols + 1];

	state_t state_q, state_nxt;
	logic [NodeCount-1:0] live_q;
	logic [CountBits-1:0] count_q;
	logic [NodeBits-1:0] next_q, idx_q, a_q, b_q;
	logic a_ok_q, b_ok_q;
	logic [SumBits-1:0] best_w_q, wa_q, rd_w_q;
	logic [NodeBits-1:0] rd_idx_q;
	logic rd_v_q;
	logic [StackBits-1:0] sp_q;
	visit_t cur_q, pop_q;
	logic [2*NodeBits-1:0] ch_q;
	out_item_t out_q;
	logic out_v_q;

	logic out_free;
	assign out_free = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_data = out_q;
	assign in_ready = (state_q == S_IDLE) && out_free;

	logic take;
	assign take = in_valid && in_ready;

	// Scan read: one weight per cycle, registered and compared in the next cycle.
	logic scan;
	assign scan = (state_q == S_SCAN_A) || (state_q == S_SCAN_B);
	logic scan_end;
	assign scan_end = scan && !rd_v_q && (idx_q == next_q);
	logic better;
	assign better = rd_v_q && live_q[rd_idx_q] &&
		!((state_q == S_SCAN_B) && rd_idx_q == a_q) &&
		((state_q == S_SCAN_A) ? (!a_ok_q || rd_w_q < best_w_q)
			: (!b_ok_q || rd_w_q < best_w_q));

	logic [CountBits:0] nmax;
	assign nmax = CountBits'(count_q) + count_q - 1'b1;

	// Classification of the visited node.
	logic leaf;
	assign leaf = cur_q.node < NodeBits'(count_q);
	logic expand;
	assign expand = !leaf && cur_q.node < next_q;

	// An item goes out on an accepted add or empty build, or on a code emission.
	logic out_set;
	assign out_set = (take && (!in_data.op || count_q == '0)) ||
		(state_q == S_OUT && out_free);

	// Result item of an accepted input item.
	out_item_t in_res;
	always_comb begin
		in_res = '0;
		in_res.last = 1'b1;
		if (!in_data.op) begin
			if (count_q != CountBits'(MaxSymbols)) begin
				in_res.status = ST_ADDED;
				in_res.symbol = count_q[SymBits-1:0];
			end else in_res.status = ST_FULL;
		end else in_res.status = ST_EMPTY;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (take && in_data.op && count_q != '0) state_nxt = S_SCAN_A;
			S_SCAN_A: if (scan_end) state_nxt = a_ok_q ? S_SCAN_B : S_POP;
			S_SCAN_B: if (scan_end) state_nxt = (b_ok_q && {1'b0, next_q} < nmax)
				? S_MERGE : S_POP;
			S_MERGE: state_nxt = S_SCAN_A;
			S_POP: state_nxt = S_POP_WAIT;
			S_POP_WAIT: state_nxt = S_VISIT;
			S_VISIT: state_nxt = leaf ? S_OUT
				: (expand ? S_POP : ((sp_q == '0) ? S_DONE : S_POP));
			S_OUT: if (out_free) state_nxt = (sp_q == '0) ? S_DONE : S_POP;
			S_DONE: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			sp_q <= '0;
			a_ok_q <= 1'b0;
			b_ok_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_set) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			rd_v_q <= scan && (idx_q != next_q);
			unique case (state_q)
				S_IDLE: if (take) begin
					if (!in_data.op) begin
						if (count_q != CountBits'(MaxSymbols)) begin
							live_q[count_q[NodeBits-1:0]] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
					end else if (count_q != '0) begin
						next_q <= NodeBits'(count_q);
						idx_q <= '0;
						a_ok_q <= 1'b0;
					end
				end
				S_SCAN_A, S_SCAN_B: begin
					if (idx_q != next_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (better) begin
						best_w_q <= rd_w_q;
						if (state_q == S_SCAN_A) begin
							a_q <= rd_idx_q; a_ok_q <= 1'b1;
						end else begin
							b_q <= rd_idx_q; b_ok_q <= 1'b1;
						end
					end
					if (scan_end) begin
						idx_q <= '0;
						b_ok_q <= 1'b0;
						if (state_q == S_SCAN_A) begin
							wa_q <= best_w_q;
							if (a_ok_q) live_q[a_q] <= 1'b0;
						end else begin
							if (b_ok_q) live_q[b_q] <= 1'b0;
						end
						if (state_nxt == S_POP) sp_q <= StackBits'(1);
					end
				end
				S_MERGE: begin
					live_q[next_q] <= 1'b1;
					next_q <= next_q + 1'b1;
					a_ok_q <= 1'b0;
				end
				S_POP: sp_q <= sp_q - 1'b1;
				S_VISIT: if (expand)
					sp_q <= sp_q + 2'd2;
				S_DONE: begin
					live_q <= '0;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Output item and datapath registers.
	always_ff @(posedge clk) begin
		rd_w_q <= wmem[idx_q];
		rd_idx_q <= idx_q;
		if (state_q == S_POP) pop_q <= smem[sp_q - 1'b1];
		if (state_q == S_POP_WAIT) begin
			cur_q <= pop_q;
			ch_q <= cmem[SymBits'(pop_q.node - NodeBits'(count_q))];
		end
		if (state_q == S_IDLE && take) begin
			out_q <= in_res;
			if (!in_data.op && count_q != CountBits'(MaxSymbols))
				wmem[count_q] <= SumBits'(in_data.weight);
		end
		if (scan_end && state_q == S_SCAN_A && !a_ok_q) begin
			smem[0] <= '0;
		end
		if (scan_end && state_q == S_SCAN_B && !(b_ok_q && {1'b0, next_q} < nmax)) begin
			smem[0] <= '{node: a_q, depth: '0, code: '0};
		end
		if (state_q == S_MERGE) begin
			wmem[next_q] <= wa_q + best_w_q;
			cmem[SymBits'(next_q - NodeBits'(count_q))] <= {a_q, b_q};
		end
		if (state_q == S_VISIT && expand) begin
			smem[sp_q] <= '{node: ch_q[NodeBits-1:0], depth: cur_q.depth + 1'b1,
				code: {cur_q.code[CodeBits-2:0], 1'b1}};
			smem[sp_q + 1'b1] <= '{node: ch_q[2*NodeBits-1:NodeBits],
				depth: cur_q.depth + 1'b1, code: {cur_q.code[CodeBits-2:0], 1'b0}};
		end
		if (state_q == S_OUT && out_free) begin
			out_q <= '{status: ST_CODE, symbol: cur_q.node[SymBits-1:0],
				code_length: cur_q.depth, code: cur_q.code, last: (sp_q == '0)};
		end
	end
endmodule
`default_nettype wire

@@ verif/huffman_code_builder_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module huffman_code_builder_tb;
	import hcb_pkg::*;

	localparam int MaxNodes = 2 * MaxSymbols - 1;
	localparam int OpAdd = 0;
	localparam int OpBuild = 1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	huffman_code_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: a copy of the symbol store.
	logic [SumBits-1:0] tree_weight [MaxNodes];
	logic tree_live [MaxNodes];
	int tree_left [MaxNodes];
	int tree_right [MaxNodes];
	int loaded_symbols;

	out_item_t pending_codes [$];
	int mismatch_count;
	bit hold_off;
	bit calm;
	bit typed_chk;
	out_item_t typed_item;

	function automatic out_item_t make_item(status_t st, int sym, int len,
			logic [CodeBits-1:0] cw, bit lst);
		out_item_t r;
		r.status = st;
		r.symbol = sym[4:0];
		r.code_length = len[4:0];
		r.code = cw;
		r.last = lst;
		return r;
	endfunction

	function automatic int lightest_live(int lim);
		int best;
		best = -1;
		for (int i = 0; i < lim; i++)
			if (tree_live[i] && (best < 0 || tree_weight[i] < tree_weight[best]))
				best = i;
		return best;
	endfunction

	// Work out the result items of one input item and queue them.
	task automatic predict_codes(in_item_t it);
		int n;
		int nxt;
		int root;
		int a;
		int b;
		int vn [$];
		int vd [$];
		logic [63:0] vc [$];
		int node;
		int dep;
		logic [63:0] cw;
		n = loaded_symbols;
		if (it.op == 1'(OpAdd)) begin
			if (n >= MaxSymbols) begin
				pending_codes.push_back(make_item(ST_FULL, 0, 0, '0, 1'b1));
			end else begin
				tree_weight[n] = SumBits'(it.weight);
				tree_live[n] = 1'b1;
				loaded_symbols = n + 1;
				pending_codes.push_back(make_item(ST_ADDED, n, 0, '0, 1'b1));
			end
			return;
		end
		if (n == 0) begin
			pending_codes.push_back(make_item(ST_EMPTY, 0, 0, '0, 1'b1));
			return;
		end
		// Merge the two lightest live nodes until one is left.
		nxt = n;
		root = 0;
		forever begin
			a = lightest_live(nxt);
			if (a < 0)
				break;
			tree_live[a] = 1'b0;
			b = lightest_live(nxt);
			if (b < 0) begin
				root = a;
				break;
			end
			tree_live[b] = 1'b0;
			tree_weight[nxt] = tree_weight[a] + tree_weight[b];
			tree_left[nxt] = a;
			tree_right[nxt] = b;
			tree_live[nxt] = 1'b1;
			nxt++;
		end
		// Left-first preorder walk over the tree.
		vn.push_back(root);
		vd.push_back(0);
		vc.push_back(64'd0);
		while (vn.size() > 0) begin
			node = vn.pop_back();
			dep = vd.pop_back();
			cw = vc.pop_back();
			if (node < n) begin
				pending_codes.push_back(make_item(ST_CODE, node, dep, cw[30:0], 1'b0));
			end else begin
				vn.push_back(tree_right[node]);
				vd.push_back(dep + 1);
				vc.push_back((cw << 1) | 64'd1);
				vn.push_back(tree_left[node]);
				vd.push_back(dep + 1);
				vc.push_back(cw << 1);
			end
		end
		pending_codes[pending_codes.size() - 1].last = 1'b1;
		for (int i = 0; i < MaxNodes; i++)
			tree_live[i] = 1'b0;
		loaded_symbols = 0;
	endtask

	// Offer one item, with random idle cycles before it, and wait for acceptance.
	task automatic send_item(bit op, logic [15:0] w);
		in_item_t it;
		it.op = op;
		it.weight = w;
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_codes(it);
		if (typed_chk)
			pending_codes[pending_codes.size() - 1] = typed_item;
		@(negedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 29);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (pending_codes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item %h", out_data);
			end else begin
				exp_item = pending_codes.pop_front();
				if (out_data !== exp_item) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected st=%0d sym=%0d len=%0d code=%h last=%b, got st=%0d sym=%0d len=%0d code=%h last=%b",
							exp_item.status, exp_item.symbol, exp_item.code_length,
							exp_item.code, exp_item.last, out_data.status,
							out_data.symbol, out_data.code_length, out_data.code,
							out_data.last);
				end
			end
		end
	end

	// Directed table: add items with extreme and equal weights, builds.
	// Rows with a typed result carry it; builds with several codes use the predictor.
	typedef struct {
		bit op;
		logic [15:0] w;
		bit chk;
		out_item_t exp;
	} stim_row_t;

	stim_row_t directed_rows [] = '{
		'{1'b1, 16'h0000, 1'b1, '{ST_EMPTY, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'hFFFF, 1'b1, '{ST_ADDED, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b1, 16'h1234, 1'b1, '{ST_CODE, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'h0000, 1'b1, '{ST_ADDED, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'hFFFF, 1'b1, '{ST_ADDED, 5'd1, 5'd0, 31'd0, 1'b1}},
		'{1'b1, 16'h0000, 1'b0, '0},
		'{1'b0, 16'h0005, 1'b1, '{ST_ADDED, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'h0005, 1'b1, '{ST_ADDED, 5'd1, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'h0005, 1'b1, '{ST_ADDED, 5'd2, 5'd0, 31'd0, 1'b1}},
		'{1'b1, 16'hFFFF, 1'b0, '0},
		'{1'b0, 16'h5555, 1'b1, '{ST_ADDED, 5'd0, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'hAAAA, 1'b1, '{ST_ADDED, 5'd1, 5'd0, 31'd0, 1'b1}},
		'{1'b0, 16'h0001, 1'b1, '{ST_ADDED, 5'd2, 5'd0, 31'd0, 1'b1}},
		'{1'b1, 16'h0000, 1'b0, '0}
	};

	initial begin
		int kind;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		calm = 1'b0;
		typed_chk = 1'b0;
		typed_item = '0;
		mismatch_count = 0;
		loaded_symbols = 0;
		for (int i = 0; i < MaxNodes; i++)
			tree_live[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			typed_chk = directed_rows[i].chk;
			typed_item = directed_rows[i].exp;
			send_item(directed_rows[i].op, directed_rows[i].w);
		end
		typed_chk = 1'b0;

		// Full store, one dropped add, then a deep tree from doubling weights.
		for (int i = 0; i < MaxSymbols; i++)
			send_item(1'b0, (i < 16) ? 16'(1 << i) : 16'hFFFF);
		send_item(1'b0, 16'h7777);
		send_item(1'b1, '0);

		// Fill up while the receiver holds off, so the input stalls.
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_item(1'b0, 16'($urandom));
		join
		send_item(1'b1, '0);

		// Random sets of mostly small size, some noise builds.
		n = 0;
		while (n < 410) begin
			calm = (n >= 200 && n < 260);
			kind = $urandom_range(99);
			if (kind < 8) begin
				send_item(1'b1, 16'($urandom));
				n++;
			end else begin
				int cnt;
				cnt = (kind < 15) ? $urandom_range(33, 20) : $urandom_range(8, 1);
				for (int j = 0; j < cnt; j++) begin
					if ($urandom_range(3) == 0)
						send_item(1'b0, 16'($urandom_range(3)));
					else
						send_item(1'b0, 16'($urandom));
				end
				send_item(1'b1, 16'($urandom));
				n += cnt + 1;
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_codes.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Guard against a hang.
	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
